>>> rtl/core/cbts_pkg.sv
// Package for the CAN bit timing solver: constants, state type, divider command.
`default_nettype none
package cbts_pkg;
   localparam logic [31:0] MIN_BITRATE  = 32'd1000;
   localparam logic [31:0] FAST_BITRATE = 32'd1000000;
   localparam logic [4:0]  FAST_SUM     = 5'd9;
   localparam logic [4:0]  SLOW_SUM     = 5'd16;
   localparam logic [31:0] MAX_PRESC    = 32'd1024;
   localparam logic [9:0]  MAX_PERMILLE = 10'd900;
   localparam logic [4:0]  MAX_SEG1     = 5'd16;
   localparam logic [4:0]  MAX_SEG2     = 5'd8;
   localparam logic [31:0] CLK_RESET    = 32'd36000000;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DIV_TOTAL, ST_WAIT_TOTAL, ST_DIV_MOD, ST_WAIT_MOD,
      ST_DIV_PERM, ST_WAIT_PERM, ST_DIV_CHECK, ST_WAIT_CHECK, ST_DONE
   } state_type;

   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [31:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic        done;
      logic [31:0] quotient;
      logic [31:0] remainder;
   } div_rsp_type;
endpackage
`default_nettype wire

>>> rtl/core/can_bit_timing_solver.sv
// CAN bit timing solver top level: config register, sequencer and shared divider.
// Each division is an issue step followed by 32 quotient bits; a request runs 0 to 18 divisions
// (none for a rate below 1000) before its result is valid.
// Throughput: one item at a time; next transfer accepted the cycle after the result transfer.
// req_stall is high from acceptance until the result transfer completes.
// Synchronous active-high reset returns to idle and loads the clock register with 36 MHz.
`default_nettype none
module can_bit_timing_solver
   import cbts_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [31:0] csr_peripheral_clock_hz,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_target_bitrate,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_unsupported,
   output logic [10:0]      rsp_prescaler,
   output logic [4:0]       rsp_segment_one,
   output logic [3:0]       rsp_segment_two,
   output logic             rsp_jump_width
);
   logic [31:0] clk_hz_ff;
   logic [4:0]  seg2_w;
   div_cmd_type div_cmd;
   div_rsp_type div_rsp;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) clk_hz_ff <= CLK_RESET;
      else if (csr_valid) clk_hz_ff <= csr_peripheral_clock_hz;
   end

   cbts_sequencer u_seq (
      .clock, .reset,
      .clk_hz(clk_hz_ff),
      .req_valid, .req_stall, .req_target_bitrate,
      .rsp_valid, .rsp_stall, .rsp_unsupported, .rsp_prescaler,
      .rsp_segment_one, .rsp_segment_two(seg2_w), .rsp_jump_width,
      .div_cmd, .div_rsp
   );

   cbts_divider u_div (.clock, .reset, .cmd(div_cmd), .rsp(div_rsp));

   assign rsp_segment_two = seg2_w[3:0];
endmodule
`default_nettype wire

>>> rtl/core/cbts_divider.sv
// Shared radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none
module cbts_divider
   import cbts_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  div_cmd_type      cmd,
   output div_rsp_type      rsp
);
   logic [31:0] quo_ff, quo_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] trial;
   logic [32:0] shifted;

   always_comb begin
      shifted = {rem_ff, quo_ff[31]};
      trial   = shifted - {1'b0, dvs_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         quo_in  = cmd.dividend;
         rem_in  = '0;
         dvs_in  = cmd.divisor;
         cnt_in  = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // partial remainder stays below the divisor, so 32 bits hold it
         if (!trial[32]) begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = shifted[31:0];
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // divide by zero yields all-ones quotient, remainder = dividend (unused here)
   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;
endmodule
`default_nettype wire

>>> rtl/core/cbts_sequencer.sv
// Sequencer: walks the quanta search and checks using the shared divider.
`default_nettype none
module cbts_sequencer
   import cbts_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [31:0] clk_hz,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_target_bitrate,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_unsupported,
   output logic [10:0]      rsp_prescaler,
   output logic [4:0]       rsp_segment_one,
   output logic [4:0]       rsp_segment_two,
   output logic             rsp_jump_width,
   output div_cmd_type      div_cmd,
   input  div_rsp_type      div_rsp
);
   state_type   state_ff, state_in;
   logic [31:0] rate_ff, rate_in;
   logic [31:0] total_ff, total_in;
   logic [4:0]  sum_ff, sum_in;
   logic [10:0] presc_ff, presc_in;
   logic [4:0]  seg1_ff, seg1_in;
   logic        fail_ff, fail_in;

   logic [4:0]  seg1_near, seg1_zero;
   logic [7:0]  sum7;
   logic [13:0] perm_num;
   logic [4:0]  seg2_w;
   logic [15:0] quanta_prod;
   logic        seg_bad;

   always_comb begin
      sum7      = {3'd0, sum_ff} * 8'd7;
      seg1_near = 5'((sum7 + 8'd3) >> 3);
      seg1_zero = 5'((sum7 - 8'd1) >> 3);
      perm_num  = ({9'd0, seg1_near} + 14'd1) * 14'd1000;
      seg2_w    = sum_ff - seg1_ff;
      quanta_prod = 16'(presc_ff * 5'(sum_ff + 5'd1));
      seg_bad   = (seg1_ff < 5'd1) || (seg1_ff > MAX_SEG1)
                  || (seg2_w < 5'd1) || (seg2_w > MAX_SEG2);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:       if (req_valid) state_in = (req_target_bitrate < MIN_BITRATE) ?
                                                  ST_DONE : ST_DIV_TOTAL;
         ST_DIV_TOTAL:  state_in = ST_WAIT_TOTAL;
         ST_WAIT_TOTAL: if (div_rsp.done) state_in = ST_DIV_MOD;
         ST_DIV_MOD:    state_in = ST_WAIT_MOD;
         ST_WAIT_MOD: begin
            if (div_rsp.done) begin
               if (div_rsp.remainder == 32'd0) state_in = ST_DIV_PERM;
               else if (sum_ff <= 5'd2) state_in = ST_DONE;
               else state_in = ST_DIV_MOD;
            end
         end
         ST_DIV_PERM:   state_in = fail_in ? ST_DONE : ST_WAIT_PERM;
         ST_WAIT_PERM:  if (div_rsp.done) state_in = ST_DIV_CHECK;
         ST_DIV_CHECK:  state_in = seg_bad ? ST_DONE : ST_WAIT_CHECK;
         ST_WAIT_CHECK: if (div_rsp.done) state_in = ST_DONE;
         ST_DONE:       if (!rsp_stall) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rate_in  = rate_ff;
      total_in = total_ff;
      sum_in   = sum_ff;
      presc_in = presc_ff;
      seg1_in  = seg1_ff;
      fail_in  = fail_ff;
      div_cmd  = '{start: 1'b0, dividend: clk_hz, divisor: rate_ff};
      unique case (state_ff)
         ST_IDLE: begin
            rate_in = req_target_bitrate;
            fail_in = req_target_bitrate < MIN_BITRATE;
            sum_in  = (req_target_bitrate >= FAST_BITRATE) ? FAST_SUM : SLOW_SUM;
         end
         ST_DIV_TOTAL: div_cmd.start = 1'b1;
         ST_WAIT_TOTAL: total_in = div_rsp.quotient;
         ST_DIV_MOD: begin
            div_cmd.start    = 1'b1;
            div_cmd.dividend = total_ff;
            div_cmd.divisor  = {27'd0, sum_ff} + 32'd1;
         end
         ST_WAIT_MOD: begin
            if (div_rsp.done) begin
               if (div_rsp.remainder != 32'd0) begin
                  if (sum_ff <= 5'd2) fail_in = 1'b1;
                  else sum_in = sum_ff - 5'd1;
               end else begin
                  presc_in = div_rsp.quotient[10:0];
                  fail_in  = (div_rsp.quotient < 32'd1) || (div_rsp.quotient > MAX_PRESC);
               end
            end
         end
         ST_DIV_PERM: begin
            fail_in          = fail_ff;
            seg1_in          = seg1_near;
            div_cmd.start    = !fail_ff;
            div_cmd.dividend = {18'd0, perm_num};
            div_cmd.divisor  = {27'd0, sum_ff} + 32'd1;
         end
         ST_WAIT_PERM: begin
            if (div_rsp.done && (div_rsp.quotient > {22'd0, MAX_PERMILLE}))
               seg1_in = seg1_zero;
         end
         ST_DIV_CHECK: begin
            fail_in          = seg_bad;
            div_cmd.start    = !seg_bad;
            div_cmd.dividend = clk_hz;
            div_cmd.divisor  = {16'd0, quanta_prod};
         end
         ST_WAIT_CHECK: begin
            if (div_rsp.done && (div_rsp.quotient != rate_ff)) fail_in = 1'b1;
         end
         ST_DONE: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      rate_ff  <= rate_in;
      total_ff <= total_in;
      sum_ff   <= sum_in;
      presc_ff <= presc_in;
      seg1_ff  <= seg1_in;
      fail_ff  <= fail_in;
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      req_stall       = (state_ff != ST_IDLE);
      rsp_valid       = (state_ff == ST_DONE);
      rsp_unsupported = fail_ff;
      rsp_prescaler   = fail_ff ? 11'd0 : presc_ff;
      rsp_segment_one = fail_ff ? 5'd0 : seg1_ff;
      rsp_segment_two = fail_ff ? 5'd0 : seg2_w;
      rsp_jump_width  = !fail_ff;
   end
endmodule
`default_nettype wire

>>> dv/can_bit_timing_solver_test.sv
// Testbench for the CAN bit timing solver: directed and random bit rates, checked per transfer.
`timescale 1ns / 100ps
`default_nettype none
module can_bit_timing_solver_test;
   import cbts_pkg::*;

   typedef struct packed {
      logic        unsupported;
      logic [10:0] prescaler;
      logic [4:0]  segment_one;
      logic [3:0]  segment_two;
      logic        jump_width;
   } timing_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_peripheral_clock_hz = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_target_bitrate = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_unsupported;
   logic [10:0] rsp_prescaler;
   logic [4:0]  rsp_segment_one;
   logic [3:0]  rsp_segment_two;
   logic        rsp_jump_width;

   logic [31:0] pending_rates[$];
   timing_type  expected_timings[$];
   logic [31:0] clock_hz_model = CLK_RESET;
   int          error_count = 0;
   int          cycle_count = 0;
   int          burst_left = 0;
   int          gap_left = 0;
   int          hold_off = 0;
   bit          hold_request = 1'b0;

   can_bit_timing_solver dut (.*);

   always #2 clock = ~clock;

   function automatic timing_type solve_timing(logic [31:0] clk_hz, logic [31:0] rate);
      timing_type  fail;
      timing_type  ok;
      logic [31:0] total;
      logic [31:0] sum;
      logic [31:0] presc;
      logic [31:0] seg1;
      logic [31:0] seg2;
      logic [31:0] permille;
      fail = '{1'b1, 11'd0, 5'd0, 4'd0, 1'b0};
      if (rate < MIN_BITRATE) return fail;
      total = clk_hz / rate;
      sum = (rate >= FAST_BITRATE) ? 32'(FAST_SUM) : 32'(SLOW_SUM);
      while ((total % (sum + 1)) != 0) begin
         if (sum <= 2) return fail;
         sum--;
      end
      presc = total / (sum + 1);
      if (presc < 1 || presc > MAX_PRESC) return fail;
      seg1 = (7 * sum + 3) / 8;
      seg2 = sum - seg1;
      permille = (1000 * (seg1 + 1)) / (sum + 1);
      if (permille > 32'(MAX_PERMILLE)) begin
         seg1 = (7 * sum - 1) / 8;
         seg2 = sum - seg1;
      end
      if (seg1 < 1 || seg1 > 32'(MAX_SEG1) || seg2 < 1 || seg2 > 32'(MAX_SEG2)) return fail;
      if (clk_hz / (presc * (seg1 + seg2 + 1)) != rate) return fail;
      ok.unsupported = 1'b0;
      ok.prescaler = presc[10:0];
      ok.segment_one = seg1[4:0];
      ok.segment_two = seg2[3:0];
      ok.jump_width = 1'b1;
      return ok;
   endfunction

   // driver: bursts and gaps; stalled payload held
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) begin
            expected_timings.push_back(solve_timing(clock_hz_model, req_target_bitrate));
            void'(pending_rates.pop_front());
         end
         if (burst_left == 0 && gap_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
         end
         if (gap_left > 0 && burst_left == 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_rates.size() > 0 && !hold_request) begin
            if (burst_left > 0) burst_left--;
            req_valid <= 1'b1;
            req_target_bitrate <= pending_rates[0];
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: own stall pattern plus a long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_off > 0) begin
            hold_off--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= (cycle_count % 512 < 200) ? 1'b0 : ($urandom_range(0, 3) == 0);
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      timing_type want;
      timing_type got;
      cycle_count++;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_unsupported, rsp_prescaler, rsp_segment_one, rsp_segment_two, rsp_jump_width};
         if (expected_timings.size() == 0) begin
            $error("unexpected result transfer");
            error_count++;
         end else begin
            want = expected_timings.pop_front();
            if (got.unsupported !== want.unsupported) begin
               $error("unsupported exp %0d got %0d", want.unsupported, got.unsupported);
               error_count++;
            end
            if (got.prescaler !== want.prescaler) begin
               $error("prescaler exp %0d got %0d", want.prescaler, got.prescaler);
               error_count++;
            end
            if (got.segment_one !== want.segment_one) begin
               $error("segment_one exp %0d got %0d", want.segment_one, got.segment_one);
               error_count++;
            end
            if (got.segment_two !== want.segment_two) begin
               $error("segment_two exp %0d got %0d", want.segment_two, got.segment_two);
               error_count++;
            end
            if (got.jump_width !== want.jump_width) begin
               $error("jump_width exp %0d got %0d", want.jump_width, got.jump_width);
               error_count++;
            end
         end
      end
      if (cycle_count > 2000000) begin
         $display("can_bit_timing_solver_test: errors");
         $finish;
      end
   end

   task automatic drain();
      wait (pending_rates.size() == 0);
      @(posedge clock);
      while (req_valid || expected_timings.size() > 0) @(posedge clock);
      repeat (700) @(posedge clock);
   endtask

   task automatic write_clock(logic [31:0] hz);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_peripheral_clock_hz <= hz;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      clock_hz_model = hz;
   endtask

   // mostly divisor-friendly rates, so solutions are common
   function automatic logic [31:0] pick_rate(logic [31:0] clk_hz);
      logic [31:0] tq;
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return $urandom_range(0, 1200);
         2: return 32'(1) << $urandom_range(0, 31);
         default: begin
            tq = $urandom_range(1, 1100) * $urandom_range(3, 17);
            return (tq == 0) ? 32'd1 : clk_hz / tq;
         end
      endcase
   endfunction

   initial begin
      logic [31:0] clock_set[6];
      logic [31:0] directed[$];
      clock_set = '{32'd80000000, 32'hFFFFFFFF, 32'd0, 32'd16000000, 32'd500, 32'd48000000};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      // reset clock first
      directed = '{32'd0, 32'd999, 32'd1000, 32'd1000000, 32'd999999, 32'd500000, 32'd250000,
                   32'd125000, 32'd100000, 32'd50000, 32'd20000, 32'd10000, 32'd3000000,
                   32'hFFFFFFFF, 32'd36000000, 32'd36000001, 32'd33333, 32'd2000000,
                   32'd1800000, 32'd83333};
      foreach (directed[i]) pending_rates.push_back(directed[i]);
      drain();
      // long receiver hold-off while the sender keeps offering
      hold_off = 3000;
      for (int i = 0; i < 30; i++) pending_rates.push_back(pick_rate(clock_hz_model));
      drain();
      foreach (clock_set[k]) begin
         write_clock(clock_set[k]);
         for (int i = 0; i < 90; i++) pending_rates.push_back(pick_rate(clock_hz_model));
         wait (pending_rates.size() < 45);
         // sender pauses until all expected results are in
         hold_request = 1'b1;
         @(posedge clock);
         while (req_valid || expected_timings.size() > 0) @(posedge clock);
         hold_request = 1'b0;
         drain();
      end
      if (error_count == 0) begin
         $display("can_bit_timing_solver_test: clean");
      end else begin
         $display("can_bit_timing_solver_test: errors");
      end
      $finish;
   end
endmodule
`default_nettype wire

>>> files.f
rtl/core/cbts_pkg.sv
rtl/core/cbts_divider.sv
rtl/core/cbts_sequencer.sv
rtl/core/can_bit_timing_solver.sv
dv/can_bit_timing_solver_test.sv
